[rtl/mme_pkg.sv]
// shared constants, types and helpers of the matrix multiply engine
package mme_pkg;

  localparam int MAX_DIM     = 8;
  localparam int FRAC_BITS   = 16;
  localparam int ROW_W       = 3;
  localparam int DIM_W       = 4;
  localparam int VAL_W       = 32;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PROD_W      = 2 * VAL_W;
  localparam int ACC_W       = PROD_W + $clog2(MAX_DIM) + 1;
  localparam int TDATA_W     = ((2 * ROW_W + VAL_W + 7) / 8) * 8;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);

  localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MULT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS    = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN =
    {{(ACC_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_MULT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [ROW_W-1:0]  row;
    logic [ROW_W-1:0]  col;
    logic [VAL_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_DRAIN
  } back_state_t;

  function automatic logic [ADDR_W-1:0] st_addr(input logic [ROW_W-1:0] r,
                                                input logic [ROW_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

endpackage

[rtl/mme_front.sv]
// input side: accepts stream transactions and turns them into queued commands
module mme_front (
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [mme_pkg::TDATA_W-1:0] in_tdata,
  input  logic [mme_pkg::MODE_W-1:0]  in_tuser,
  input  mme_pkg::q_stat_t            q_stat,
  output logic                        q_push,
  output mme_pkg::cmd_t               q_cmd
);

  logic                       keep;
  logic                       in_range;
  logic [mme_pkg::ROW_W-1:0]  row;
  logic [mme_pkg::ROW_W-1:0]  col;

  assign row = in_tdata[mme_pkg::ROW_W-1:0];
  assign col = in_tdata[2*mme_pkg::ROW_W-1:mme_pkg::ROW_W];
  assign in_range = (int'(row) < mme_pkg::MAX_DIM) && (int'(col) < mme_pkg::MAX_DIM);

  always_comb begin
    q_cmd.row   = row;
    q_cmd.col   = col;
    q_cmd.value = in_tdata[2*mme_pkg::ROW_W+mme_pkg::VAL_W-1:2*mme_pkg::ROW_W];
    q_cmd.kind  = mme_pkg::CMD_MULT;
    keep        = 1'b0;
    unique case (in_tuser)
      mme_pkg::MODE_LOAD_A: begin
        q_cmd.kind = mme_pkg::CMD_LOAD_A;
        keep       = in_range;
      end
      mme_pkg::MODE_LOAD_B: begin
        q_cmd.kind = mme_pkg::CMD_LOAD_B;
        keep       = in_range;
      end
      mme_pkg::MODE_MULT: begin
        q_cmd.kind = mme_pkg::CMD_MULT;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_tready = !q_stat.full;
  assign q_push    = in_tvalid && in_tready && keep;

endmodule

[rtl/mme_cmd_fifo.sv]
// command queue between the front and back parts
module mme_cmd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mme_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output mme_pkg::cmd_t    pop_cmd,
  output mme_pkg::q_stat_t stat
);

  mme_pkg::cmd_t               fifo_mem_r [mme_pkg::Q_DEPTH];
  logic [mme_pkg::Q_PTR_W-1:0] wr_ptr_r;
  logic [mme_pkg::Q_PTR_W-1:0] rd_ptr_r;
  logic [mme_pkg::Q_PTR_W:0]   cnt_r;
  logic                        push_ok;
  logic                        pop_ok;

  assign stat.full  = (cnt_r == (mme_pkg::Q_PTR_W+1)'(mme_pkg::Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign push_ok    = push && !stat.full;
  assign pop_ok     = pop && !stat.empty;
  assign pop_cmd    = fifo_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      fifo_mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= wr_ptr_r + mme_pkg::Q_PTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + mme_pkg::Q_PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
        cnt_r <= cnt_r + (mme_pkg::Q_PTR_W+1)'(1);
      end else if (pop_ok && !push_ok) begin
        cnt_r <= cnt_r - (mme_pkg::Q_PTR_W+1)'(1);
      end
    end
  end

endmodule

[rtl/mme_back.sv]
// execution side: matrix stores, dimension registers, multiply-accumulate and output register
module mme_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]     cfg_data,
  input  mme_pkg::q_stat_t              q_stat,
  input  mme_pkg::cmd_t                 q_cmd,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mme_pkg::TDATA_W-1:0]   out_tdata,
  output logic                          out_tlast
);

  mme_pkg::back_state_t state_r, state_nxt;

  logic [mme_pkg::DIM_W-1:0] a_rows_r, inner_dim_r, b_cols_r;
  logic [mme_pkg::ROW_W-1:0] rn_m1_r, kn_m1_r, cn_m1_r;
  logic [mme_pkg::ROW_W-1:0] i_r, j_r, k_r;

  logic [mme_pkg::VAL_W-1:0] a_mem [mme_pkg::STORE_DEPTH];
  logic [mme_pkg::VAL_W-1:0] b_mem [mme_pkg::STORE_DEPTH];
  logic [mme_pkg::VAL_W-1:0] a_rd_r, b_rd_r;
  logic                      v1_r, l1_r, v2_r, l2_r;
  logic signed [mme_pkg::PROD_W-1:0] prod_r;
  logic signed [mme_pkg::ACC_W-1:0]  acc_r;
  logic signed [mme_pkg::ACC_W-1:0]  acc_q;
  logic                              acc_done_r;

  logic                      out_valid_r;
  logic [mme_pkg::ROW_W-1:0] out_row_r, out_col_r;
  logic [mme_pkg::VAL_W-1:0] out_value_r;
  logic                      out_last_r;
  logic [mme_pkg::VAL_W-1:0] sat_value;

  logic start_mult, wr_a, wr_b, issue, finish, out_free, last_elem, last_k;

  function automatic logic [mme_pkg::ROW_W-1:0] dim_m1(input logic [mme_pkg::DIM_W-1:0] raw);
    logic [mme_pkg::DIM_W-1:0] d;
    d = raw;
    if (raw == '0) begin
      d = mme_pkg::DIM_W'(1);
    end else if (int'(raw) > mme_pkg::MAX_DIM) begin
      d = mme_pkg::DIM_W'(mme_pkg::MAX_DIM);
    end
    return mme_pkg::ROW_W'(d - mme_pkg::DIM_W'(1));
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r    <= mme_pkg::DIM_RESET;
      inner_dim_r <= mme_pkg::DIM_RESET;
      b_cols_r    <= mme_pkg::DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mme_pkg::REG_A_ROWS:    a_rows_r    <= cfg_data;
        mme_pkg::REG_INNER_DIM: inner_dim_r <= cfg_data;
        mme_pkg::REG_B_COLS:    b_cols_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign last_elem = (i_r == rn_m1_r) && (j_r == cn_m1_r);
  assign last_k    = (k_r == kn_m1_r);
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mme_pkg::BK_IDLE: begin
        if (!q_stat.empty && q_cmd.kind == mme_pkg::CMD_MULT) begin
          state_nxt = mme_pkg::BK_ISSUE;
        end
      end
      mme_pkg::BK_ISSUE: begin
        if (last_k) begin
          state_nxt = mme_pkg::BK_DRAIN;
        end
      end
      mme_pkg::BK_DRAIN: begin
        if (acc_done_r && out_free) begin
          state_nxt = last_elem ? mme_pkg::BK_IDLE : mme_pkg::BK_ISSUE;
        end
      end
      default: state_nxt = mme_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    start_mult = 1'b0;
    wr_a       = 1'b0;
    wr_b       = 1'b0;
    issue      = 1'b0;
    finish     = 1'b0;
    unique case (state_r)
      mme_pkg::BK_IDLE: begin
        q_pop      = !q_stat.empty;
        start_mult = q_pop && (q_cmd.kind == mme_pkg::CMD_MULT);
        wr_a       = q_pop && (q_cmd.kind == mme_pkg::CMD_LOAD_A);
        wr_b       = q_pop && (q_cmd.kind == mme_pkg::CMD_LOAD_B);
      end
      mme_pkg::BK_ISSUE: begin
        issue = 1'b1;
      end
      mme_pkg::BK_DRAIN: begin
        finish = acc_done_r && out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mme_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start_mult) begin
      rn_m1_r <= dim_m1(a_rows_r);
      kn_m1_r <= dim_m1(inner_dim_r);
      cn_m1_r <= dim_m1(b_cols_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      j_r <= '0;
      k_r <= '0;
    end else begin
      if (start_mult) begin
        i_r <= '0;
        j_r <= '0;
        k_r <= '0;
      end else begin
        if (issue) begin
          k_r <= last_k ? '0 : k_r + mme_pkg::ROW_W'(1);
        end
        if (finish) begin
          if (j_r == cn_m1_r) begin
            j_r <= '0;
            i_r <= i_r + mme_pkg::ROW_W'(1);
          end else begin
            j_r <= j_r + mme_pkg::ROW_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_mem[mme_pkg::st_addr(q_cmd.row, q_cmd.col)] <= q_cmd.value;
    end
    if (issue) begin
      a_rd_r <= a_mem[mme_pkg::st_addr(i_r, k_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      b_mem[mme_pkg::st_addr(q_cmd.row, q_cmd.col)] <= q_cmd.value;
    end
    if (issue) begin
      b_rd_r <= b_mem[mme_pkg::st_addr(k_r, j_r)];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed(a_rd_r) * $signed(b_rd_r);
    if (start_mult || finish) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + {{(mme_pkg::ACC_W-mme_pkg::PROD_W){prod_r[mme_pkg::PROD_W-1]}}, prod_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      l1_r       <= 1'b0;
      v2_r       <= 1'b0;
      l2_r       <= 1'b0;
      acc_done_r <= 1'b0;
    end else begin
      v1_r <= issue;
      l1_r <= issue && last_k;
      v2_r <= v1_r;
      l2_r <= l1_r;
      if (finish) begin
        acc_done_r <= 1'b0;
      end else if (v2_r && l2_r) begin
        acc_done_r <= 1'b1;
      end
    end
  end

  assign acc_q = acc_r >>> mme_pkg::FRAC_BITS;

  always_comb begin
    if (acc_q > mme_pkg::SAT_MAX) begin
      sat_value = mme_pkg::SAT_MAX[mme_pkg::VAL_W-1:0];
    end else if (acc_q < mme_pkg::SAT_MIN) begin
      sat_value = mme_pkg::SAT_MIN[mme_pkg::VAL_W-1:0];
    end else begin
      sat_value = acc_q[mme_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_row_r   <= i_r;
      out_col_r   <= j_r;
      out_value_r <= sat_value;
      out_last_r  <= last_elem;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(mme_pkg::TDATA_W-2*mme_pkg::ROW_W-mme_pkg::VAL_W){1'b0}},
                       out_value_r, out_col_r, out_row_r};

endmodule

[rtl/matrix_multiply_engine.sv]
// top level of the matrix multiply engine
//
// in_* stream: one transaction per matrix element load or multiply command.
//   in_tuser is the mode (load A, load B, multiply); in_tdata carries the
//   row, column and Q16.16 value of a load. Loads are accepted one per
//   cycle while the command queue has room.
// cfg_* channel: writes a_rows, inner_dim and b_cols; always ready; it is to be
//   written only while the engine is idle, which the block does not enforce.
// out_* stream: a multiply emits a_rows x b_cols product elements (each
//   dimension clamped to 1..8) in row-major order, out_tlast on the final one.
// each product element is accumulated in the single multiply-accumulate
//   pipeline fed by one read port per store.
// reset (rst_n low, synchronous) empties the queue, returns the dimension
//   registers to 8 and drops any run in progress; stored elements are kept.
// when out_tready is low the result register holds its transaction, the
//   next product waits, and new input fills the queue until it is full.
module matrix_multiply_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mme_pkg::TDATA_W-1:0]   in_tdata,   // row_index, col_index, elem_value
  input  logic [mme_pkg::MODE_W-1:0]    in_tuser,   // mode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mme_pkg::TDATA_W-1:0]   out_tdata,  // out_row, out_col, out_value
  output logic                          out_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]     cfg_data
);

  mme_pkg::q_stat_t q_stat;
  mme_pkg::cmd_t    push_cmd;
  mme_pkg::cmd_t    pop_cmd;
  logic             q_push;
  logic             q_pop;

  mme_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  mme_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .stat     (q_stat)
  );

  mme_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_stat     (q_stat),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[rtl/mme_checker.sv]
// port-level checker of the matrix multiply engine and its bind
module mme_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [mme_pkg::TDATA_W-1:0]   out_tdata,
  input logic                          out_tlast
);

  localparam int PAY_W = 2 * mme_pkg::ROW_W + mme_pkg::VAL_W;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("out transaction changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out valid after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[mme_pkg::TDATA_W-1:PAY_W] == '0)
    else $error("out tdata padding not zero");

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (.*);

[test/tb_matrix_multiply_engine.sv]
`timescale 1ns / 100ps
// self-checking testbench of the matrix multiply engine with a fixed-point product predictor
module tb_matrix_multiply_engine;
  import mme_pkg::*;

  localparam logic [MODE_W-1:0]    MODE_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 2'd3;
  localparam int                   RANDOM_ITEMS  = 220;
  localparam int                   MAX_GAP       = 18;
  localparam int                   SETTLE_CYCLES = 24;
  localparam int                   STALL_LIMIT   = 1000;
  localparam int                   REPORT_MAX    = 10;
  localparam int                   WIDE_W        = 72;

  localparam logic signed [WIDE_W-1:0] Q_MAX = 72'sh7FFFFFFF;
  localparam logic signed [WIDE_W-1:0] Q_MIN = -72'sh80000000;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             last;
  } product_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ROW_W-1:0]  row;
    logic [ROW_W-1:0]  col;
  } load_slot_t;

  class product_board;
    logic signed [VAL_W-1:0] a_mem [MAX_DIM][MAX_DIM];
    logic signed [VAL_W-1:0] b_mem [MAX_DIM][MAX_DIM];
    logic [DIM_W-1:0]        rows_reg;
    logic [DIM_W-1:0]        inner_reg;
    logic [DIM_W-1:0]        cols_reg;
    product_t                product_fifo [$];
    int                      errors;

    function new();
      rows_reg  = DIM_RESET;
      inner_reg = DIM_RESET;
      cols_reg  = DIM_RESET;
      errors    = 0;
    endfunction

    function int span(logic [DIM_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_DIM) return MAX_DIM;
      return int'(raw);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      case (idx)
        REG_A_ROWS:    rows_reg  = data;
        REG_INNER_DIM: inner_reg = data;
        REG_B_COLS:    cols_reg  = data;
        default: ;
      endcase
    endfunction

    // exact sum of products, floor shift, saturate to 32 bits
    function logic [VAL_W-1:0] dot_q16(int i, int j, int kn);
      logic signed [WIDE_W-1:0] acc;
      logic signed [WIDE_W-1:0] av;
      logic signed [WIDE_W-1:0] bv;
      logic signed [WIDE_W-1:0] q;
      acc = '0;
      for (int k = 0; k < kn; k++) begin
        av  = a_mem[i][k];
        bv  = b_mem[k][j];
        acc = acc + av * bv;
      end
      q = acc >>> FRAC_BITS;
      if (q > Q_MAX) return 32'h7FFFFFFF;
      if (q < Q_MIN) return 32'h80000000;
      return q[VAL_W-1:0];
    endfunction

    function void note_input(logic [MODE_W-1:0] mode, logic [ROW_W-1:0] row,
                             logic [ROW_W-1:0] col, logic [VAL_W-1:0] value);
      int       rn;
      int       kn;
      int       cn;
      product_t p;
      rn = span(rows_reg);
      kn = span(inner_reg);
      cn = span(cols_reg);
      case (mode)
        MODE_LOAD_A: a_mem[row][col] = value;
        MODE_LOAD_B: b_mem[row][col] = value;
        MODE_MULT: begin
          for (int i = 0; i < rn; i++) begin
            for (int j = 0; j < cn; j++) begin
              p.row   = ROW_W'(i);
              p.col   = ROW_W'(j);
              p.value = dot_q16(i, j, kn);
              p.last  = (i == rn - 1) && (j == cn - 1);
              product_fifo.push_back(p);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [ROW_W-1:0] row, logic [ROW_W-1:0] col,
                               logic [VAL_W-1:0] value, logic last);
      product_t want;
      if (product_fifo.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected result: row %0d col %0d value %h last %b",
                   row, col, value, last);
        return;
      end
      want = product_fifo.pop_front();
      if (want.row !== row || want.col !== col ||
          want.value !== value || want.last !== last) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("mismatch: want r%0d c%0d %h last %b, got r%0d c%0d %h last %b",
                   want.row, want.col, want.value, want.last, row, col, value, last);
      end
    endfunction

    function int pending();
      return product_fifo.size();
    endfunction
  endclass

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata   = '0;
  logic [MODE_W-1:0]    in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [TDATA_W-1:0]   out_tdata;
  logic                 out_tlast;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [DIM_W-1:0]     cfg_data   = '0;

  product_board board = new();
  bit           a_loaded [MAX_DIM][MAX_DIM];
  bit           b_loaded [MAX_DIM][MAX_DIM];
  int           random_items = 0;
  bit           send_burst   = 1'b0;
  bit           take_burst   = 1'b0;

  matrix_multiply_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [ROW_W-1:0] row,
                           input logic [ROW_W-1:0] col, input logic [VAL_W-1:0] value);
    int gap;
    if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= TDATA_W'({value, col, row});
    do @(posedge clk); while (!in_tready);
    board.note_input(mode, row, col, value);
    if (mode == MODE_LOAD_A) a_loaded[row][col] = 1'b1;
    else if (mode == MODE_LOAD_B) b_loaded[row][col] = 1'b1;
  endtask

  // hold off input until every product is out and the pipeline is empty
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 32'h80000000;
          1:       return 32'h7FFFFFFF;
          2:       return 32'h00000000;
          default: return 32'hFFFFFFFF;
        endcase
      end
      1, 2, 3: return VAL_W'($urandom_range(0, 32'h80000)) - 32'h40000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 11))
      0:       return 4'd0;
      1:       return DIM_W'($urandom_range(9, 15));
      2:       return 4'd8;
      default: return DIM_W'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: send_item(MODE_UNUSED, ROW_W'($urandom), ROW_W'($urandom), $urandom());
      1: begin
        send_item(MODE_LOAD_A, ROW_W'($urandom), ROW_W'($urandom), pick_value());
        random_items++;
      end
      default: begin
        send_item(MODE_LOAD_B, ROW_W'($urandom), ROW_W'($urandom), pick_value());
        random_items++;
      end
    endcase
  endtask

  task automatic run_phase(input logic [DIM_W-1:0] raw_rows, input logic [DIM_W-1:0] raw_inner,
                           input logic [DIM_W-1:0] raw_cols);
    load_slot_t plan [$];
    load_slot_t tmp;
    int         rn;
    int         kn;
    int         cn;
    int         pick;
    int         mults;
    settle();
    write_reg(REG_A_ROWS, raw_rows);
    write_reg(REG_INNER_DIM, raw_inner);
    write_reg(REG_B_COLS, raw_cols);
    if ($urandom_range(0, 1) == 1) write_reg(REG_SPARE, DIM_W'($urandom));
    rn    = board.span(raw_rows);
    kn    = board.span(raw_inner);
    cn    = board.span(raw_cols);
    mults = $urandom_range(1, 2);
    repeat (mults) begin
      plan.delete();
      for (int i = 0; i < rn; i++)
        for (int k = 0; k < kn; k++)
          if (!a_loaded[i][k] || $urandom_range(0, 2) == 0)
            plan.push_back('{MODE_LOAD_A, ROW_W'(i), ROW_W'(k)});
      for (int k = 0; k < kn; k++)
        for (int j = 0; j < cn; j++)
          if (!b_loaded[k][j] || $urandom_range(0, 2) == 0)
            plan.push_back('{MODE_LOAD_B, ROW_W'(k), ROW_W'(j)});
      for (int n = plan.size() - 1; n > 0; n--) begin
        pick       = $urandom_range(0, n);
        tmp        = plan[n];
        plan[n]    = plan[pick];
        plan[pick] = tmp;
      end
      foreach (plan[n]) begin
        if ($urandom_range(0, 7) == 0) send_noise();
        send_item(plan[n].mode, plan[n].row, plan[n].col, pick_value());
        random_items++;
      end
      send_item(MODE_MULT, ROW_W'($urandom), ROW_W'($urandom), $urandom());
      random_items++;
    end
  endtask

  task automatic directed_cases();
    write_reg(REG_A_ROWS, 4'd1);
    write_reg(REG_INNER_DIM, 4'd2);
    write_reg(REG_B_COLS, 4'd2);
    // largest negative squared, then mixed signs: both saturation directions
    send_item(MODE_LOAD_A, 3'd0, 3'd0, 32'h80000000);
    send_item(MODE_LOAD_A, 3'd0, 3'd1, 32'h80000000);
    send_item(MODE_LOAD_B, 3'd0, 3'd0, 32'h80000000);
    send_item(MODE_LOAD_B, 3'd1, 3'd0, 32'h80000000);
    send_item(MODE_LOAD_B, 3'd0, 3'd1, 32'h7FFFFFFF);
    send_item(MODE_LOAD_B, 3'd1, 3'd1, 32'h00000000);
    send_item(MODE_LOAD_A, 3'd7, 3'd7, 32'hFFFFFFFF);
    send_item(MODE_LOAD_B, 3'd7, 3'd7, 32'h00000000);
    send_item(MODE_UNUSED, 3'd7, 3'd7, 32'hFFFFFFFF);
    send_item(MODE_MULT, 3'd7, 3'd7, 32'hFFFFFFFF);
    // tiny negative products round toward minus infinity
    send_item(MODE_LOAD_A, 3'd0, 3'd0, 32'hFFFFFFFF);
    send_item(MODE_LOAD_A, 3'd0, 3'd1, 32'h00010000);
    send_item(MODE_LOAD_B, 3'd0, 3'd0, 32'h00000001);
    send_item(MODE_LOAD_B, 3'd1, 3'd0, 32'h00000000);
    send_item(MODE_LOAD_B, 3'd0, 3'd1, 32'h00018000);
    send_item(MODE_LOAD_B, 3'd1, 3'd1, 32'hFFFF8000);
    send_item(MODE_UNUSED, 3'd0, 3'd0, 32'h00000000);
    send_item(MODE_MULT, 3'd0, 3'd0, 32'h00000000);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    directed_cases();
    settle();
    run_phase(4'd15, 4'd8, 4'd9);
    run_phase(4'd0, 4'd0, 4'd0);
    run_phase(4'd8, 4'd1, 4'd1);
    while (random_items < RANDOM_ITEMS)
      run_phase(pick_dim(), pick_dim(), pick_dim());
    settle();
    if (board.pending() != 0)
      $display("%0d expected products never arrived", board.pending());
    if (board.pending() == 0 && board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 19) == 0) take_burst = !take_burst;
      stall = take_burst ? 0 : $urandom_range(0, MAX_GAP);
      repeat (stall) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      board.check_result(out_tdata[ROW_W-1:0], out_tdata[2*ROW_W-1:ROW_W],
                         out_tdata[2*ROW_W+VAL_W-1:2*ROW_W], out_tlast);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule

[filelist.f]
rtl/mme_pkg.sv
rtl/mme_front.sv
rtl/mme_cmd_fifo.sv
rtl/mme_back.sv
rtl/matrix_multiply_engine.sv
rtl/mme_checker.sv
test/tb_matrix_multiply_engine.sv
